>>> rtl/core/aprq_pkg.sv
// ----------------------------------------------------------------------------
// aprq_pkg
// Types and codes shared by the aging priority ready queue.
// ----------------------------------------------------------------------------
package aprq_pkg;

    localparam int unsigned CLASSES  = 4;
    localparam int unsigned CAPACITY = 64;
    localparam int unsigned GEN_BITS = 16;

    typedef enum logic [1:0] {
        K_READY  = 2'd0,
        K_NEXT   = 2'd1,
        K_REMOVE = 2'd2,
        K_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_SOFT  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RDY_WR,
        S_NXT_RD,
        S_NXT_WAIT,
        S_NXT_DONE,
        S_RM_RD,
        S_RM_CHK,
        S_RM_SHIFT_RD,
        S_RM_SHIFT_WR,
        S_RM_DONE,
        S_CLEAR,
        S_REPLY
    } t_state;

    localparam int unsigned PASS_BITS = 16;

endpackage

>>> rtl/core/aging_priority_ready_queue.sv
// ----------------------------------------------------------------------------
// aging_priority_ready_queue
// Multilevel FIFO ready queue with per-class aging; entries and generations kept in RAMs.
// ----------------------------------------------------------------------------
// One word at a time: busy stays high until the result cycle; a new word is taken no earlier.
// Result strobe o_valid lasts one cycle; the receiver cannot stall.
// After reset the generation RAM is cleared while busy is high.
module aging_priority_ready_queue
    import aprq_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cfg_we,
    input  logic [15:0]                 i_cfg_data,
    input  logic [1:0]                  i_kind,
    input  logic [5:0]                  i_task_index,
    input  logic [15:0]                 i_task_generation,
    input  logic [1:0]                  i_priority_req,
    output logic                        o_valid,
    output logic [1:0]                  o_status,
    output logic [5:0]                  o_out_index,
    output logic [15:0]                 o_out_generation,
    output logic [1:0]                  o_served_class
);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int unsigned NW = $clog2(CAPACITY + 1);
    localparam int unsigned EW = IW + GEN_BITS;

    t_state r_state, n_state;

    logic [EW-1:0]       ring_mem [CLASSES*CAPACITY];
    logic [GEN_BITS-1:0] gen_mem  [CAPACITY];

    logic [IW-1:0]        r_head  [CLASSES];
    logic [NW-1:0]        r_count [CLASSES];
    logic [PASS_BITS-1:0] r_pass  [CLASSES];
    logic [PASS_BITS-1:0] r_limit;

    t_kind               r_kind;
    logic [5:0]          r_idx;
    logic [GEN_BITS-1:0] r_gen;
    logic [1:0]          r_cls;
    logic                r_bad;
    logic [CW-1:0]       r_sc;
    logic [NW-1:0]       r_k;
    logic [IW-1:0]       r_clr;

    logic [EW-1:0]       r_ring_q;
    logic [GEN_BITS-1:0] r_gen_q;

    logic [1:0]  r_status;
    logic [5:0]  r_oidx;
    logic [15:0] r_ogen;
    logic [1:0]  r_ocls;
    logic        r_valid;

    // ring/gen RAM ports
    logic                ring_we, ring_re, gen_we;
    logic [CW+IW-1:0]    ring_wa, ring_ra;
    logic [EW-1:0]       ring_wd;
    logic [IW-1:0]       gen_a;
    logic [GEN_BITS-1:0] gen_wd;

    always_ff @(posedge i_clk) begin
        if (ring_we) ring_mem[ring_wa] <= ring_wd;
        if (ring_re) r_ring_q <= ring_mem[ring_ra];
        if (gen_we) gen_mem[gen_a] <= gen_wd;
        r_gen_q <= gen_mem[gen_a];
    end

    // class choice for next
    logic          any_work;
    logic [CW-1:0] sel_cls;
    always_comb begin
        logic          have_aged;
        logic [CW-1:0] best;
        have_aged = 1'b0;
        best      = '0;
        any_work  = 1'b0;
        sel_cls   = '0;
        for (int i = CLASSES - 1; i >= 0; i--) begin
            if (r_count[i] != '0 && r_pass[i] >= r_limit &&
                (!have_aged || r_pass[i] > r_pass[best])) begin
                best      = CW'(i);
                have_aged = 1'b1;
            end
        end
        for (int i = 0; i < CLASSES; i++) begin
            if (r_count[i] != '0) begin
                sel_cls  = CW'(i);
                any_work = 1'b1;
            end
        end
        if (have_aged) sel_cls = best;
    end

    logic [IW-1:0] slot_k, slot_k1;
    assign slot_k  = IW'((NW+1)'(r_head[r_sc]) + (NW+1)'(r_k) -
                     (((NW+1)'(r_head[r_sc]) + (NW+1)'(r_k)) >= (NW+1)'(CAPACITY) ?
                      (NW+1)'(CAPACITY) : '0));
    assign slot_k1 = (slot_k == IW'(CAPACITY - 1)) ? '0 : slot_k + 1'b1;

    logic [IW-1:0] tail;
    assign tail = IW'((NW+1)'(r_head[r_cls]) + (NW+1)'(r_count[r_cls]) -
                  (((NW+1)'(r_head[r_cls]) + (NW+1)'(r_count[r_cls])) >= (NW+1)'(CAPACITY) ?
                   (NW+1)'(CAPACITY) : '0));

    logic match;
    assign match = r_ring_q == {r_idx[IW-1:0], r_gen};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == IW'(CAPACITY - 1)) n_state = S_IDLE;
            S_IDLE:   if (start) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_kind == K_READY)
                    n_state = (r_bad || r_gen_q != '0) ? S_REPLY : S_RDY_WR;
                else if (r_kind == K_NEXT)
                    n_state = any_work ? S_NXT_RD : S_REPLY;
                else if (r_kind == K_REMOVE)
                    n_state = (r_bad || r_gen_q != r_gen) ? S_REPLY : S_RM_RD;
                else
                    n_state = S_REPLY;
            end
            S_RDY_WR:   n_state = S_REPLY;
            S_NXT_RD:   n_state = S_NXT_WAIT;
            S_NXT_WAIT: n_state = S_NXT_DONE;
            S_NXT_DONE: n_state = S_REPLY;
            S_RM_RD: begin
                if (r_k >= r_count[r_sc])
                    n_state = (r_sc == CW'(CLASSES - 1)) ? S_REPLY : S_RM_RD;
                else
                    n_state = S_RM_CHK;
            end
            S_RM_CHK:      n_state = match ? S_RM_SHIFT_RD : S_RM_RD;
            S_RM_SHIFT_RD: n_state = (r_k + 1'b1 >= r_count[r_sc]) ? S_RM_DONE
                                                                   : S_RM_SHIFT_WR;
            S_RM_SHIFT_WR: n_state = S_RM_SHIFT_RD;
            S_RM_DONE:     n_state = S_REPLY;
            S_REPLY:       n_state = S_IDLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        ring_we = 1'b0;
        ring_re = 1'b0;
        ring_wa = '0;
        ring_ra = '0;
        ring_wd = r_ring_q;
        gen_we  = 1'b0;
        gen_a   = r_idx[IW-1:0];
        gen_wd  = '0;
        unique case (r_state)
            S_IDLE:  gen_a = i_task_index[IW-1:0];
            S_CLEAR: begin
                gen_we = 1'b1;
                gen_a  = r_clr;
            end
            S_RDY_WR: begin
                ring_we = 1'b1;
                ring_wa = {r_cls[CW-1:0], tail};
                ring_wd = {r_idx[IW-1:0], r_gen};
                gen_we  = 1'b1;
                gen_wd  = r_gen;
            end
            S_NXT_RD: begin
                ring_re = 1'b1;
                ring_ra = {r_sc, r_head[r_sc]};
            end
            S_NXT_DONE: begin
                gen_we = 1'b1;
                gen_a  = r_ring_q[EW-1 -: IW];
            end
            S_RM_RD, S_RM_SHIFT_RD: begin
                ring_re = 1'b1;
                ring_ra = {r_sc, (r_state == S_RM_SHIFT_RD) ? slot_k1 : slot_k};
            end
            S_RM_SHIFT_WR: begin
                ring_we = 1'b1;
                ring_wa = {r_sc, slot_k};
            end
            S_RM_DONE: gen_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_limit <= 16'd4;
            r_valid <= 1'b0;
            for (int i = 0; i < CLASSES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_pass[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_REPLY);
            if (i_cfg_we) r_limit <= i_cfg_data;
            unique case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: if (start) begin
                    r_kind <= t_kind'(i_kind);
                    r_idx  <= i_task_index;
                    r_gen  <= i_task_generation[GEN_BITS-1:0];
                    r_cls  <= i_priority_req;
                    r_bad  <= i_task_generation[GEN_BITS-1:0] == '0 ||
                              32'(i_task_index) >= CAPACITY ||
                              (t_kind'(i_kind) == K_READY && 32'(i_priority_req) >= CLASSES);
                    r_status <= ST_SOFT;
                    r_oidx <= '0;
                    r_ogen <= '0;
                    r_ocls <= '0;
                    r_sc   <= '0;
                    r_k    <= '0;
                end
                S_DECIDE: begin
                    if (r_kind == K_READY)
                        r_status <= r_bad ? ST_ERROR :
                                    (r_gen_q == r_gen) ? ST_SOFT :
                                    (r_gen_q != '0) ? ST_ERROR : ST_DONE;
                    else if (r_kind == K_UNUSED)
                        r_status <= ST_ERROR;
                    if (r_kind == K_NEXT && any_work) begin
                        r_sc <= sel_cls;
                        for (int i = 0; i < CLASSES; i++) begin
                            if (CW'(i) == sel_cls)
                                r_pass[i] <= '0;
                            else if (CW'(i) < sel_cls && r_count[i] != '0 &&
                                     r_pass[i] != '1)
                                r_pass[i] <= r_pass[i] + 1'b1;
                        end
                    end
                end
                S_RDY_WR: r_count[r_cls] <= r_count[r_cls] + 1'b1;
                S_NXT_RD: begin
                    r_head[r_sc]  <= (r_head[r_sc] == IW'(CAPACITY - 1)) ? '0
                                                                         : r_head[r_sc] + 1'b1;
                    r_count[r_sc] <= r_count[r_sc] - 1'b1;
                end
                S_NXT_DONE: begin
                    r_status <= ST_DONE;
                    r_oidx   <= 6'(r_ring_q[EW-1 -: IW]);
                    r_ogen   <= 16'(r_ring_q[GEN_BITS-1:0]);
                    r_ocls   <= 2'(r_sc);
                end
                S_RM_RD: if (r_k >= r_count[r_sc]) begin
                    r_sc <= r_sc + 1'b1;
                    r_k  <= '0;
                end
                S_RM_CHK: if (!match) r_k <= r_k + 1'b1;
                S_RM_SHIFT_WR: r_k <= r_k + 1'b1;
                S_RM_DONE: begin
                    r_count[r_sc] <= r_count[r_sc] - 1'b1;
                    if (r_count[r_sc] == NW'(1)) r_pass[r_sc] <= '0;
                    r_status <= ST_DONE;
                end
                default: ;
            endcase
        end
    end

    assign busy             = r_state != S_IDLE;
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_out_index      = r_oidx;
    assign o_out_generation = r_ogen;
    assign o_served_class   = r_ocls;

endmodule

>>> rtl/core/aprq_checker.sv
// ----------------------------------------------------------------------------
// aprq_checker
// Port-level checks for the aging priority ready queue.
// ----------------------------------------------------------------------------
module aprq_checker
    import aprq_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [1:0]  o_status,
    input logic [1:0]  o_served_class
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("not busy after start");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe too long");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_DONE || o_status == ST_SOFT || o_status == ST_ERROR))
        else $error("bad status");
    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("busy with result");
    a_class_zero_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_DONE |-> o_served_class == '0)
        else $error("class set on a failed word");
endmodule

bind aging_priority_ready_queue aprq_checker u_aprq_checker (.*);

>>> verif/aging_priority_ready_queue_tb.sv
// ----------------------------------------------------------------------------
// aging_priority_ready_queue_tb
// Self-checking bench for the aging priority ready queue. A clocked driver
// feeds make ready / next / remove words from a pending queue. A predictor
// keeps its own class rings, pass-over counts and generation table and
// predicts the result of each accepted word. A clocked monitor checks every
// strobed result, field by field, against the oldest prediction. Runs across
// several aging limits, the extremes among them.
// ----------------------------------------------------------------------------
module aging_priority_ready_queue_tb
    import aprq_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS = 4;
    localparam int NSLOT = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int CALM_TAIL = 150;

    typedef struct {
        bit          is_cfg;
        logic [15:0] cfg_value;
        t_kind       kind;
        logic [5:0]  idx;
        logic [15:0] gen;
        logic [1:0]  cls;
    } t_word;

    typedef struct {
        t_status     status;
        logic [5:0]  idx;
        logic [15:0] gen;
        logic [1:0]  cls;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic [1:0]  i_kind = '0;
    logic [5:0]  i_task_index = '0;
    logic [15:0] i_task_generation = '0;
    logic [1:0]  i_priority_req = '0;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [5:0]  o_out_index;
    logic [15:0] o_out_generation;
    logic [1:0]  o_served_class;

    aging_priority_ready_queue dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_kind            (i_kind),
        .i_task_index      (i_task_index),
        .i_task_generation (i_task_generation),
        .i_priority_req    (i_priority_req),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_out_index       (o_out_index),
        .o_out_generation  (o_out_generation),
        .o_served_class    (o_served_class)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // shadow of the queue state
    logic [15:0] aging_lim = 16'd4;
    logic [15:0] gen_table [NSLOT];
    logic [5:0]  ring_idx [NCLS][NSLOT];
    logic [15:0] ring_gen [NCLS][NSLOT];
    logic [5:0]  ring_head [NCLS];
    int          ring_cnt [NCLS];
    int          passed [NCLS];
    int          queued_total = 0;

    t_word   pending_q [$];
    t_result expected_q [$];
    int      fail_cnt = 0;
    int      n_served = 0;
    int      n_accepted = 0;
    int      n_cfg = 0;
    int      idle_cycles = 0;

    initial begin
        for (int i = 0; i < NSLOT; i++) gen_table[i] = '0;
        for (int c = 0; c < NCLS; c++) begin
            ring_head[c] = '0;
            ring_cnt[c] = 0;
            passed[c] = 0;
        end
    end

    function automatic t_result predict_queue_op(t_kind kind, logic [5:0] idx,
                                                 logic [15:0] gen, logic [1:0] cls);
        t_result r;
        int served;
        bit have;
        logic [5:0] pos;
        r = '{ST_DONE, '0, '0, '0};
        case (kind)
            K_READY: begin
                if (gen == 0) r.status = ST_ERROR;
                else if (gen_table[idx] == gen) r.status = ST_SOFT;
                else if (gen_table[idx] != 0) r.status = ST_ERROR;
                else if (ring_cnt[cls] >= NSLOT) r.status = ST_ERROR;
                else begin
                    pos = ring_head[cls] + 6'(ring_cnt[cls]);
                    ring_idx[cls][pos] = idx;
                    ring_gen[cls][pos] = gen;
                    ring_cnt[cls]++;
                    gen_table[idx] = gen;
                    queued_total++;
                end
            end
            K_NEXT: begin
                if (queued_total == 0) begin
                    r.status = ST_SOFT;
                end else begin
                    have = 0;
                    served = 0;
                    for (int c = NCLS - 1; c >= 0; c--)
                        if (ring_cnt[c] > 0 && passed[c] >= aging_lim &&
                            (!have || passed[c] > passed[served])) begin
                            served = c;
                            have = 1;
                        end
                    if (!have)
                        for (int c = NCLS - 1; c >= 0; c--)
                            if (!have && ring_cnt[c] > 0) begin
                                served = c;
                                have = 1;
                            end
                    for (int c = 0; c < served; c++)
                        if (ring_cnt[c] > 0 && passed[c] < 65535) passed[c]++;
                    passed[served] = 0;
                    pos = ring_head[served];
                    r.idx = ring_idx[served][pos];
                    r.gen = ring_gen[served][pos];
                    r.cls = 2'(served);
                    ring_head[served] = pos + 6'd1;
                    ring_cnt[served]--;
                    gen_table[r.idx] = '0;
                    queued_total--;
                end
            end
            K_REMOVE: begin
                r.status = ST_SOFT;
                if (gen != 0 && gen_table[idx] == gen) begin
                    for (int c = 0; c < NCLS; c++)
                        for (int k = 0; k < ring_cnt[c]; k++) begin
                            pos = ring_head[c] + 6'(k);
                            if (r.status == ST_SOFT && ring_idx[c][pos] == idx &&
                                ring_gen[c][pos] == gen) begin
                                for (int m = k; m + 1 < ring_cnt[c]; m++) begin
                                    ring_idx[c][ring_head[c] + 6'(m)] =
                                        ring_idx[c][ring_head[c] + 6'(m + 1)];
                                    ring_gen[c][ring_head[c] + 6'(m)] =
                                        ring_gen[c][ring_head[c] + 6'(m + 1)];
                                end
                                ring_cnt[c]--;
                                if (ring_cnt[c] == 0) passed[c] = 0;
                                gen_table[idx] = '0;
                                queued_total--;
                                r.status = ST_DONE;
                            end
                        end
                end
            end
            default: r.status = ST_ERROR;
        endcase
        return r;
    endfunction

    // driver
    int settle = 0;
    int gap = 0;
    always @(posedge i_clk) begin
        logic nxt_start;
        logic nxt_we;
        logic [15:0] nxt_data;
        t_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            nxt_start = start;
            nxt_we = 1'b0;
            nxt_data = i_cfg_data;
            w = '{0, '0, t_kind'(i_kind), i_task_index, i_task_generation, i_priority_req};
            if (start && !busy) begin
                expected_q.push_back(predict_queue_op(w.kind, w.idx, w.gen, w.cls));
                n_accepted++;
                nxt_start = 1'b0;
            end
            if (!nxt_start) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_q.size() > 0) begin
                    if (pending_q[0].is_cfg) begin
                        if (expected_q.size() == 0 && !busy) begin
                            if (settle < 8) settle++;
                            else begin
                                nxt_we = 1'b1;
                                nxt_data = pending_q[0].cfg_value;
                                aging_lim = pending_q[0].cfg_value;
                                n_cfg++;
                                void'(pending_q.pop_front());
                                settle = 0;
                            end
                        end else settle = 0;
                    end else if (pending_q.size() > CALM_TAIL &&
                                 $urandom_range(0, 5) == 0) begin
                        gap = $urandom_range(1, 3) - 1;
                    end else begin
                        w = pending_q.pop_front();
                        nxt_start = 1'b1;
                    end
                end
            end
            start <= nxt_start;
            i_cfg_we <= nxt_we;
            i_cfg_data <= nxt_data;
            i_kind <= w.kind;
            i_task_index <= w.idx;
            i_task_generation <= w.gen;
            i_priority_req <= w.cls;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_result e;
        if (o_valid) begin
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                fail_cnt++;
            end else begin
                e = expected_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    fail_cnt++;
                end
                if (o_out_index !== e.idx) begin
                    $error("out_index: expected %0d actual %0d", e.idx, o_out_index);
                    fail_cnt++;
                end
                if (o_out_generation !== e.gen) begin
                    $error("out_generation: expected %0d actual %0d",
                           e.gen, o_out_generation);
                    fail_cnt++;
                end
                if (o_served_class !== e.cls) begin
                    $error("served_class: expected %0d actual %0d", e.cls, o_served_class);
                    fail_cnt++;
                end
                if (e.status == ST_DONE && e.gen != 0) n_served++;
            end
        end
        if ((start && !busy) || o_valid || i_cfg_we) idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d words outstanding", expected_q.size());
            $display("aging_priority_ready_queue: mismatch");
            $finish;
        end else idle_cycles <= idle_cycles + 1;
    end

    // stimulus
    logic [15:0] live_gen [NSLOT];

    task automatic push_op(t_kind k, int idx, logic [15:0] g, int c);
        pending_q.push_back('{0, '0, k, 6'(idx), g, 2'(c)});
    endtask

    task automatic push_cfg(logic [15:0] v);
        pending_q.push_back('{1, v, K_NEXT, '0, '0, '0});
    endtask

    task automatic push_random_op(int fill_pct, int span);
        int r;
        int idx;
        logic [15:0] g;
        r = $urandom_range(0, 99);
        idx = $urandom_range(0, span);
        g = live_gen[idx];
        if ($urandom_range(0, 19) == 0) g = 16'($urandom);
        if ($urandom_range(0, 49) == 0) g = '0;
        if ($urandom_range(0, 39) == 0) live_gen[idx] = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 79) == 0)
            push_op(K_UNUSED, idx, g, $urandom_range(0, 3));
        else if (r < fill_pct)
            push_op(K_READY, idx, g, $urandom_range(0, 3));
        else if (r < fill_pct + (100 - fill_pct) * 2 / 3)
            push_op(K_NEXT, $urandom_range(0, 63), 16'($urandom), $urandom_range(0, 3));
        else
            push_op(K_REMOVE, idx, g, $urandom_range(0, 3));
    endtask

    initial begin
        logic [15:0] limits [6];
        for (int i = 0; i < NSLOT; i++) live_gen[i] = 16'($urandom_range(1, 65535));

        // directed
        push_op(K_NEXT, 0, 16'd1, 0);
        push_op(K_READY, 0, 16'd0, 3);
        push_op(K_READY, 63, 16'hFFFF, 3);
        push_op(K_READY, 63, 16'hFFFF, 3);
        push_op(K_READY, 63, 16'h1234, 0);
        push_op(K_READY, 0, 16'd1, 0);
        push_op(K_READY, 21, 16'h5555, 1);
        push_op(K_READY, 42, 16'hAAAA, 2);
        push_op(K_READY, 7, 16'h0077, 0);
        push_op(K_REMOVE, 5, 16'd9, 0);
        push_op(K_REMOVE, 0, 16'd0, 0);
        push_op(K_REMOVE, 0, 16'd2, 0);
        push_op(K_REMOVE, 0, 16'd1, 0);
        push_op(K_UNUSED, 63, 16'hFFFF, 3);
        for (int i = 0; i < 6; i++) push_op(K_NEXT, 0, 16'd0, 0);
        push_op(K_NEXT, 0, 16'd0, 0);

        limits = '{16'd0, 16'd1, 16'hFFFF, 16'd4, 16'($urandom_range(2, 8)), 16'd3};
        foreach (limits[p]) begin
            push_cfg(limits[p]);
            // fill one class to capacity, push one more, then partly drain, wrapping its ring
            if (p == 2) begin
                for (int i = 0; i < NSLOT; i++) push_op(K_READY, i, live_gen[i], 1);
                push_op(K_READY, 5, live_gen[5], 1);
                for (int i = 0; i < 40; i++) push_op(K_NEXT, 0, '0, 0);
            end
            for (int chunk = 0; chunk < 5; chunk++) begin
                int fill;
                int span;
                fill = (chunk % 2 == 0) ? 70 : 30;
                span = ($urandom_range(0, 2) == 0) ? 15 : 63;
                for (int i = 0; i < 35; i++) push_random_op(fill, span);
            end
        end
        push_cfg(16'd4);
        for (int i = 0; i < 80; i++) push_random_op(50, 63);
        for (int i = 0; i < 70; i++) push_op(K_NEXT, 0, '0, 0);

        wait (i_rst_n);
        while (pending_q.size() > 0 || start) @(posedge i_clk);
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_q.size() > 0) begin
            $error("%0d results never arrived", expected_q.size());
            fail_cnt++;
        end
        $display("covered %0d words (%0d tasks served) over %0d aging limits",
                 n_accepted, n_served, n_cfg);
        if (fail_cnt == 0) $display("aging_priority_ready_queue: match");
        else $display("aging_priority_ready_queue: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/aprq_pkg.sv
rtl/core/aging_priority_ready_queue.sv
rtl/core/aprq_checker.sv
verif/aging_priority_ready_queue_tb.sv
